// ===== rtl/core/tmw_pkg.sv =====
// Shared types and constants for the text-mode terminal writer.
// Request/response payload structs, command classes and character codes.
// No dependencies.
`default_nettype none

package tmw_pkg;

	// character codes: three with a control meaning, and the space
	localparam logic [7:0]  CODE_NEWLINE = 8'd10;
	localparam logic [7:0]  CODE_RETURN  = 8'd13;
	localparam logic [7:0]  CODE_TAB     = 8'd9;
	localparam logic [7:0]  CODE_SPACE   = 8'h20;

	localparam int          TAB_STEP     = 4;
	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]  COLOR_RESET  = 8'd7;
	localparam logic [0:0]  OP_PUT       = 1'b0;
	localparam logic [0:0]  OP_READ      = 1'b1;

	typedef struct packed {
		logic [0:0] opcode;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic [0:0]  did_scroll;
	} rsp_t;

	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_NEWLINE,
		CMD_RETURN,
		CMD_TAB,
		CMD_READ,
		CMD_READ_BLANK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmw_front.sv =====
// Front end: accepts requests, classifies them into commands and buffers them.
// Two-entry command queue toward the back end. Depends on tmw_pkg.
`default_nettype none

module tmw_front #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  tmw_pkg::req_t   req_data,
	output logic            cmd_valid,
	input  wire             cmd_pop,
	output tmw_pkg::cmd_t   cmd
);
	import tmw_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       decoded;
	logic       push;

	// classify; out-of-screen reads are resolved here
	always_comb begin
		decoded.char_code   = req_data.char_code;
		decoded.read_row    = req_data.read_row;
		decoded.read_column = req_data.read_column;
		if (req_data.opcode == OP_READ) begin
			if (req_data.read_row < SCREEN_ROWS && req_data.read_column < SCREEN_COLUMNS)
				decoded.kind = CMD_READ;
			else
				decoded.kind = CMD_READ_BLANK;
		end else begin
			unique case (req_data.char_code)
				CODE_NEWLINE: decoded.kind = CMD_NEWLINE;
				CODE_RETURN:  decoded.kind = CMD_RETURN;
				CODE_TAB:     decoded.kind = CMD_TAB;
				default:      decoded.kind = CMD_PRINT;
			endcase
		end
	end

	assign req_ready = (count_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= decoded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop)
				count_q <= count_q + 2'd1;
			else if (!push && cmd_pop)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tmw_back.sv =====
// Back end: cursor, screen store, scroll fill and response register.
// Screen rows are addressed through a rotating top-row pointer. Depends on tmw_pkg.
`default_nettype none

module tmw_back #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	output logic            cmd_pop,
	input  tmw_pkg::cmd_t   cmd,
	input  wire [7:0]       text_color,
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output tmw_pkg::rsp_t   rsp_data
);
	import tmw_pkg::*;

	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int RW    = $clog2(SCREEN_ROWS);
	localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_READ, ST_FILL} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [CW-1:0]   fill_col_q;
	logic [RW-1:0]   fill_row_q;
	logic [7:0]      fill_attr_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   top_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic [15:0]     screen_q [CELLS];
	logic [15:0]     mem_rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [15:0]     mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;

	logic            rsp_free;
	logic            rsp_load;
	logic            go;
	logic            wrap;
	logic            scroll;
	logic [CW:0]     col_inc;
	logic [CW:0]     col_tab;
	logic [RW-1:0]   nxt_row;
	logic [CW-1:0]   nxt_col;
	logic [RW-1:0]   nxt_top;

	// logical row to physical row through the top pointer
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
		input logic [RW-1:0] top);
		logic [RW:0] s;
		s = {1'b0, lrow} + {1'b0, top};
		if (s >= (RW+1)'(SCREEN_ROWS))
			s = s - (RW+1)'(SCREEN_ROWS);
		return s[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
		input logic [CW-1:0] col);
		return AW'(prow * SCREEN_COLUMNS + col);
	endfunction

	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign go       = (state_q == ST_RUN) && cmd_valid && rsp_free;
	// a response is loaded at the end of a read, or at once for anything else
	assign rsp_load = (state_q == ST_READ) || (go && cmd.kind != CMD_READ);
	assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
	assign col_tab  = ({1'b0, col_q} + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		wrap      = 1'b0;
		scroll    = 1'b0;
		nxt_row   = row_q;
		nxt_col   = col_q;
		nxt_top   = top_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = BLANK_CELL;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(fill_row_q, fill_col_q);
				mem_wdata = {fill_attr_q, CODE_SPACE};
			end
			ST_RUN: begin
				if (go) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						CMD_PRINT: begin
							mem_we    = 1'b1;
							mem_waddr = cell_addr(phys_row(row_q, top_q), col_q);
							mem_wdata = {text_color, cmd.char_code};
							if (col_inc >= (CW+1)'(SCREEN_COLUMNS))
								wrap = 1'b1;
							else
								nxt_col = col_inc[CW-1:0];
						end
						CMD_NEWLINE: wrap = 1'b1;
						CMD_RETURN:  nxt_col = '0;
						CMD_TAB: begin
							if (col_tab >= (CW+1)'(SCREEN_COLUMNS))
								wrap = 1'b1;
							else
								nxt_col = col_tab[CW-1:0];
						end
						CMD_READ: begin
							mem_re    = 1'b1;
							mem_raddr = cell_addr(phys_row(cmd.read_row[RW-1:0], top_q),
								cmd.read_column[CW-1:0]);
						end
						default: ;
					endcase
				end
			end
			ST_READ: ;
			default: ;
		endcase

		// next line; past the last row the top pointer rotates instead
		if (wrap) begin
			nxt_col = '0;
			if (row_q == RW'(SCREEN_ROWS - 1)) begin
				scroll  = 1'b1;
				nxt_top = (top_q == RW'(SCREEN_ROWS - 1)) ? '0 : top_q + RW'(1);
			end else begin
				nxt_row = row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			screen_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= screen_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fill_col_q  <= '0;
			fill_row_q  <= '0;
			fill_attr_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1))
						state_q <= ST_RUN;
				end
				ST_FILL: begin
					fill_col_q <= fill_col_q + CW'(1);
					if (fill_col_q == CW'(SCREEN_COLUMNS - 1))
						state_q <= ST_RUN;
				end
				ST_READ: begin
					rsp_q.cell_value      <= mem_rdata_q;
					rsp_q.cursor_row      <= 5'(row_q);
					rsp_q.cursor_column   <= 7'(col_q);
					rsp_q.did_scroll      <= 1'b0;
					state_q               <= ST_RUN;
				end
				ST_RUN: begin
					if (go) begin
						row_q <= nxt_row;
						col_q <= nxt_col;
						top_q <= nxt_top;
						if (cmd.kind == CMD_READ) begin
							state_q <= ST_READ;
						end else begin
							rsp_q.cell_value    <= '0;
							rsp_q.cursor_row    <= 5'(nxt_row);
							rsp_q.cursor_column <= 7'(nxt_col);
							rsp_q.did_scroll    <= scroll;
						end
						// old top row becomes the new bottom row
						if (scroll) begin
							state_q     <= ST_FILL;
							fill_row_q  <= top_q;
							fill_col_q  <= '0;
							fill_attr_q <= text_color;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/text_mode_terminal_writer.sv =====
// Top level of the text-mode terminal writer: front end, back end, color register.
// Depends on tmw_pkg, tmw_front and tmw_back.
// Each request yields exactly one response. Character, newline, return and tab
// requests run at one request per cycle while the receiver takes each response
// and no scroll fill is pending; a read passes through ST_READ (registered memory
// read port) and no other command is taken until its response is loaded. A
// request that scrolls the screen answers at once, after which the back end
// blanks the new bottom row in ST_FILL: scrolling rotates a top-row pointer
// rather than moving cells, so the fill of that one row sets the cost. After
// reset the back end clears the whole screen store to grey spaces, one cell per
// cycle; requests are queued meanwhile and color writes are taken as always.
`default_nettype none

module text_mode_terminal_writer #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire             clk,
	input  wire             arst_n,
	// request channel
	input  wire             req_valid,
	output logic            req_ready,
	input  tmw_pkg::req_t   req_data,
	// response channel
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output tmw_pkg::rsp_t   rsp_data,
	// color register write
	input  wire             cfg_valid,
	output logic            cfg_ready,
	input  wire [7:0]       cfg_data
);
	import tmw_pkg::*;

	logic       cmd_valid;
	logic       cmd_pop;
	cmd_t       cmd;
	logic [7:0] text_color_q;

	// Attribute for printed cells and scroll fill; always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			text_color_q <= COLOR_RESET;
		else if (cfg_valid)
			text_color_q <= cfg_data;
	end

	// Front end decodes each request and parks it in a two-entry queue.
	tmw_front #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// Back end owns the cursor and the screen store and drives responses.
	tmw_back #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.text_color (text_color_q),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tmw_checker.sv =====
// Port-level checks for the text-mode terminal writer, bound to its top level.
// Depends on tmw_pkg and text_mode_terminal_writer.
`default_nettype none

module tmw_checker #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input wire            clk,
	input wire            arst_n,
	input wire            rsp_valid,
	input wire            rsp_ready,
	input tmw_pkg::rsp_t  rsp_data
);
	import tmw_pkg::*;

	// stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.cursor_row < SCREEN_ROWS
			&& rsp_data.cursor_column < SCREEN_COLUMNS)
		else $error("cursor off screen");

	// a scroll always lands at the start of the bottom row
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.did_scroll |->
			rsp_data.cursor_row == SCREEN_ROWS - 1 && rsp_data.cursor_column == 0)
		else $error("scroll left cursor off the bottom row start");

	// a scroll answer carries no cell
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.did_scroll |-> rsp_data.cell_value == 16'h0)
		else $error("scroll response with cell data");

endmodule

bind text_mode_terminal_writer tmw_checker #(
	.SCREEN_COLUMNS (SCREEN_COLUMNS),
	.SCREEN_ROWS    (SCREEN_ROWS)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for text_mode_terminal_writer: random and directed terminal
// traffic is checked against an in-bench shadow of the screen store and the cursor.
// Depends on tmw_pkg and the text_mode_terminal_writer RTL.
`timescale 1ns / 100ps

module tb_top;
	import tmw_pkg::*;

	localparam int COLS           = 80;
	localparam int ROWS           = 25;
	// covers the bottom-row blanking that follows a scroll, with margin
	localparam int SETTLE_CYCLES  = 2 * COLS + 20;
	// receiver hold-off used to fill the block and stall its request side
	localparam int HOLD_CYCLES    = 400;
	// outlasts the post-reset screen clear of all ROWS * COLS cells
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 240;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req_data  = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;

	// shadow copy of the block state, updated on every accepted request and color write
	logic [15:0] shadow_screen [ROWS*COLS];
	logic [4:0]  shadow_row;
	logic [6:0]  shadow_col;
	logic [7:0]  shadow_color;

	rsp_t queued_reports[$];   // cursor/cell reports still owed by the block
	int   issued_count   = 0;  // requests accepted, counted by the sender
	int   reported_count = 0;  // responses taken by the checker
	int   mismatch_count = 0;

	// idling controls shared by sender and receiver
	bit sender_gaps     = 1'b1;
	bit receiver_stalls = 1'b1;
	bit hold_responses  = 1'b0;

	text_mode_terminal_writer #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow terminal
	// ------------------------------------------------------------------

	function automatic void reset_shadow();
		int i;
		for (i = 0; i < ROWS * COLS; i++)
			shadow_screen[i] = BLANK_CELL;
		shadow_row   = '0;
		shadow_col   = '0;
		shadow_color = COLOR_RESET;
	endfunction

	// Cursor to column 0 of the next row; at the last row the screen moves up
	// one row and the bottom row is blanked in the current color.
	function automatic bit shadow_line_feed();
		int i;
		shadow_col = '0;
		if (shadow_row == ROWS - 1) begin
			for (i = 0; i < (ROWS - 1) * COLS; i++)
				shadow_screen[i] = shadow_screen[i + COLS];
			for (i = 0; i < COLS; i++)
				shadow_screen[(ROWS - 1) * COLS + i] = {shadow_color, CODE_SPACE};
			return 1'b1;
		end
		shadow_row = shadow_row + 1'b1;
		return 1'b0;
	endfunction

	// Applies one request to the shadow and returns the response it must produce.
	function automatic rsp_t advance_terminal(input req_t r);
		rsp_t rep;
		int   next_col;
		rep = '0;
		if (r.opcode == OP_READ) begin
			// out-of-range reads answer 0
			if (r.read_row < ROWS && r.read_column < COLS)
				rep.cell_value = shadow_screen[r.read_row * COLS + r.read_column];
		end else if (r.char_code == CODE_NEWLINE) begin
			rep.did_scroll = shadow_line_feed();
		end else if (r.char_code == CODE_RETURN) begin
			shadow_col = '0;
		end else if (r.char_code == CODE_TAB) begin
			next_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
			if (next_col >= COLS)
				rep.did_scroll = shadow_line_feed();
			else
				shadow_col = 7'(next_col);
		end else begin
			shadow_screen[shadow_row * COLS + shadow_col] = {shadow_color, r.char_code};
			if (shadow_col == COLS - 1)
				rep.did_scroll = shadow_line_feed();
			else
				shadow_col = shadow_col + 1'b1;
		end
		rep.cursor_row    = shadow_row;
		rep.cursor_column = shadow_col;
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Checker: tracks color writes and requests, compares each response
	// ------------------------------------------------------------------

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				shadow_color = cfg_data;
			if (req_valid && req_ready)
				queued_reports.push_back(advance_terminal(req_data));
			if (rsp_valid && rsp_ready) begin
				reported_count++;
				if (queued_reports.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: response expected none, actual %h", $time, rsp_data);
				end else begin
					want = queued_reports.pop_front();
					compare_field("cell_value", want.cell_value, rsp_data.cell_value);
					compare_field("cursor_row", 16'(want.cursor_row),
						16'(rsp_data.cursor_row));
					compare_field("cursor_column", 16'(want.cursor_column),
						16'(rsp_data.cursor_column));
					compare_field("did_scroll", 16'(want.did_scroll),
						16'(rsp_data.did_scroll));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_responses) begin
				hold_responses = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 4) == 0) begin
				stall_left = gap_length();
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when nothing moves on any channel for too long
	// ------------------------------------------------------------------

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t ns: watchdog expired", $time);
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request and returns at the edge where it is taken. With no gap
	// drawn, valid stays high so the next call continues the burst.
	task automatic send_request(input req_t r);
		int gap;
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		issued_count++;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			gap = gap_length();
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender pauses until every owed response is back
	task automatic wait_for_reports();
		req_valid <= 1'b0;
		while (reported_count < issued_count)
			@(posedge clk);
	endtask

	// color register is to be written only with the block idle; this task does not enforce it
	task automatic write_text_color(input logic [7:0] color);
		cfg_valid <= 1'b1;
		cfg_data  <= color;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] printable_code();
		logic [7:0] code;
		do code = 8'($urandom_range(0, 255));
		while (code == CODE_NEWLINE || code == CODE_RETURN || code == CODE_TAB);
		return code;
	endfunction

	// put request; the read coordinates are don't-care and get random bits
	function automatic req_t put_code(input logic [7:0] code);
		req_t r;
		r.opcode      = OP_PUT;
		r.char_code   = code;
		r.read_row    = 5'($urandom_range(0, 31));
		r.read_column = 7'($urandom_range(0, 127));
		return r;
	endfunction

	// read request; char_code is ignored by the block and gets random bits
	function automatic req_t read_cell(input int row, input int col);
		req_t r;
		r.opcode      = OP_READ;
		r.char_code   = 8'($urandom_range(0, 255));
		r.read_row    = 5'(row);
		r.read_column = 7'(col);
		return r;
	endfunction

	// Random terminal traffic: mostly text, with controls and reads mixed in.
	// Reads favor the cursor row so freshly written cells get read back.
	function automatic req_t random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			if ($urandom_range(0, 9) == 0)
				return read_cell($urandom_range(0, 31), $urandom_range(0, 127));
			if ($urandom_range(0, 1) == 0)
				return read_cell(int'(shadow_row), $urandom_range(0, COLS - 1));
			return read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
		end
		if (pick < 32)
			return put_code(CODE_NEWLINE);
		if (pick < 35)
			return put_code(CODE_RETURN);
		if (pick < 41)
			return put_code(CODE_TAB);
		return put_code(8'($urandom_range(0, 255)));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset contents, out-of-range reads, byte extremes and every control code.
	task automatic test_directed_edits();
		write_text_color(8'h1E);
		send_request(read_cell(0, 0));
		send_request(read_cell(ROWS - 1, COLS - 1));
		send_request(read_cell(31, 127));          // both coordinates off screen
		send_request(read_cell(ROWS, 0));          // first row past the bottom
		send_request(read_cell(0, COLS));          // first column past the edge
		send_request(put_code(8'h00));
		send_request(put_code(8'hFF));
		send_request(put_code(CODE_SPACE));
		send_request(read_cell(0, 0));
		send_request(read_cell(0, 1));
		send_request(put_code(CODE_TAB));          // column 3 -> 4
		send_request(put_code(CODE_TAB));          // 4 -> 8, already aligned
		send_request(put_code(CODE_RETURN));
		send_request(put_code(CODE_NEWLINE));
		send_request(put_code(CODE_TAB));          // 0 -> 4
		send_request(put_code(8'h41));
		send_request(read_cell(1, 4));
		send_request(read_cell(1, 5));
	endtask

	// One phase of random traffic in a given color. Idling is redrawn every
	// few dozen requests so some stretches run with no gaps at all.
	task automatic test_text_in_color(input logic [7:0] color);
		int n;
		wait_for_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_text_color(color);
		for (n = 0; n < PHASE_ITEMS; n++) begin
			if (n % 40 == 0) begin
				sender_gaps     = $urandom_range(0, 3) != 0;
				receiver_stalls = $urandom_range(0, 3) != 0;
			end
			send_request(random_request());
		end
	endtask

	// Lines run up to and past the right edge: a tab from the last tab stop or
	// beyond must start a new line, and a full line must wrap (and scroll when
	// the cursor is already on the bottom row).
	task automatic test_line_edges();
		int widths [6];
		int w;
		int k;
		widths = '{76, 77, 78, 79, 80, 83};
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		for (w = 0; w < 6; w++) begin
			send_request(put_code(CODE_RETURN));
			for (k = 0; k < widths[w]; k++)
				send_request(put_code(printable_code()));
			send_request(put_code(CODE_TAB));
			send_request(read_cell(ROWS - 1, $urandom_range(0, COLS - 1)));
			send_request(read_cell(ROWS - 2, $urandom_range(0, COLS - 1)));
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the
	// block fills up and stalls its request side; then the sender drains.
	task automatic test_receiver_hold_off();
		int n;
		wait_for_reports();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		hold_responses  = 1'b1;
		for (n = 0; n < 60; n++)
			send_request(random_request());
		wait_for_reports();
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		for (n = 0; n < 20; n++)
			send_request(random_request());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_edits();
		test_text_in_color(8'h00);
		test_text_in_color(8'hFF);
		test_line_edges();
		test_receiver_hold_off();
		test_text_in_color(8'h5A);
		test_text_in_color(8'($urandom_range(0, 255)));
		test_text_in_color(COLOR_RESET);

		wait_for_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (queued_reports.size() != 0) begin
			mismatch_count++;
			$display("%0t ns: %0d responses never arrived", $time, queued_reports.size());
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
